// ----- rtl/scfr_pkg.sv -----
// ----------------------------------------------------------------------------
// scfr_pkg
// Shared types and constants of the start-character / CR LF frame receiver.
// ----------------------------------------------------------------------------
package scfr_pkg;

   localparam int LEN_W   = 8;
   localparam int BYTE_W  = 8;
   localparam int INDEX_W = 7;
   localparam int KIND_W  = 2;

   localparam logic [BYTE_W-1:0] START_CHAR      = 8'h2A;
   localparam logic [BYTE_W-1:0] LINE_FEED       = 8'h0A;
   localparam logic [BYTE_W-1:0] CARRIAGE_RETURN = 8'h0D;

   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE    = 2'd0,
      KIND_READ    = 2'd1,
      KIND_RELEASE = 2'd2
   } kind_type;

   // One classified item travelling from the front to the back.
   typedef struct packed {
      logic              frame_ready;
      logic [LEN_W-1:0]  frame_length;
      logic              read_valid;
      logic [LEN_W-1:0]  read_addr;
      logic              write_en;
      logic [LEN_W-1:0]  write_addr;
      logic [BYTE_W-1:0] write_data;
   } cmd_type;

endpackage

// ----- rtl/start_char_crlf_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// start_char_crlf_frame_receiver
// Captures an asterisk-started, CR LF terminated ASCII frame for software.
// ----------------------------------------------------------------------------
// Each item is a received byte, a read of one store entry or a release of
// the held frame, and each item yields exactly one result carrying the frame
// status after that item (ready flag and held length) plus the read byte on
// a valid read. An asterisk always restarts the frame; other bytes append
// until the store of BUFFER_DEPTH bytes is full; a line feed preceded by a
// carriage return completes the frame once three or more bytes are held, and
// the frame then ignores all bytes but an asterisk until released. The block
// takes one item per clock while the queue has room: the front classifies the
// item and updates the status registers in the cycle of acceptance, a
// two-entry queue carries the classified item to the back, and the back
// performs the single store write or registered store read and holds the
// result in its output registers; either side may stall without stopping
// the other until the queue fills. The store has no reset; only entries
// below the held length can be read, and those have always been written.
// ----------------------------------------------------------------------------
module start_char_crlf_frame_receiver import scfr_pkg::*; #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   input  logic [INDEX_W-1:0] req_read_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_ready,
   output logic [LEN_W-1:0]   rsp_frame_length,
   output logic               rsp_read_valid,
   output logic [BYTE_W-1:0]  rsp_read_data
);

   // front to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   // queue to back
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_data;

   // Classify items and advance the frame status on acceptance.
   scfr_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_rx_byte    (req_rx_byte),
      .req_read_index (req_read_index),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // Decouple the two halves so that each may stall on its own.
   scfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Write or read the store in item order and hold the result.
   scfr_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_data         (pop_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_frame_ready  (rsp_frame_ready),
      .rsp_frame_length (rsp_frame_length),
      .rsp_read_valid   (rsp_read_valid),
      .rsp_read_data    (rsp_read_data)
   );

endmodule

// ----- rtl/scfr_front.sv -----
// ----------------------------------------------------------------------------
// scfr_front
// Accepts items, keeps frame status and issues store writes and reads.
// ----------------------------------------------------------------------------
module scfr_front import scfr_pkg::*; #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [BYTE_W-1:0]  req_rx_byte,
   input  logic [INDEX_W-1:0] req_read_index,
   output logic               push_valid,
   input  logic               push_ready,
   output cmd_type            push_data
);

   localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);

   logic [LEN_W-1:0]  len_ff, len_in;
   logic              complete_ff, complete_in;
   logic [BYTE_W-1:0] last_ff, last_in;   // store[len-1]
   logic [BYTE_W-1:0] prev_ff, prev_in;   // store[len-2]
   logic              accept;
   logic              has_room;
   logic [LEN_W-1:0]  index_ext;

   assign accept     = req_valid && push_ready;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign has_room   = (len_ff < DEPTH_LEN);
   assign index_ext  = LEN_W'(req_read_index);

   always_comb begin
      len_in      = len_ff;
      complete_in = complete_ff;
      last_in     = last_ff;
      prev_in     = prev_ff;
      push_data   = '0;
      unique case (req_kind)
         KIND_BYTE: begin
            if (req_rx_byte == START_CHAR) begin
               complete_in          = 1'b0;
               len_in               = LEN_W'(1);
               last_in              = req_rx_byte;
               push_data.write_en   = 1'b1;
               push_data.write_addr = '0;
               push_data.write_data = req_rx_byte;
            end else if (!complete_ff) begin
               if (has_room) begin
                  len_in               = len_ff + LEN_W'(1);
                  prev_in              = last_ff;
                  last_in              = req_rx_byte;
                  push_data.write_en   = 1'b1;
                  push_data.write_addr = len_ff;
                  push_data.write_data = req_rx_byte;
               end
               // a full store drops the byte but still checks the held tail
               if (req_rx_byte == LINE_FEED) begin
                  if (has_room) begin
                     if (len_ff >= LEN_W'(2) && last_ff == CARRIAGE_RETURN) begin
                        complete_in = 1'b1;
                     end
                  end else if (prev_ff == CARRIAGE_RETURN) begin
                     complete_in = 1'b1;
                  end
               end
            end
         end
         KIND_READ: begin
            if (complete_ff && index_ext < len_ff && index_ext < DEPTH_LEN) begin
               push_data.read_valid = 1'b1;
               push_data.read_addr  = index_ext;
            end
         end
         KIND_RELEASE: begin
            if (complete_ff && len_ff != '0) begin
               complete_in = 1'b0;
               len_in      = '0;
            end
         end
         default: begin
         end
      endcase
      push_data.frame_ready  = complete_in;
      push_data.frame_length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= '0;
         complete_ff <= 1'b0;
      end else if (accept) begin
         len_ff      <= len_in;
         complete_ff <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= last_in;
         prev_ff <= prev_in;
      end
   end

   a_len_bounded : assert property (@(posedge clock) disable iff (reset)
      len_ff <= DEPTH_LEN)
      else $error("held length exceeds the store depth");

   a_complete_len : assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> len_ff >= LEN_W'(3))
      else $error("frame complete with fewer than three bytes");

   a_start_restarts : assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_BYTE && req_rx_byte == START_CHAR
      |=> len_ff == LEN_W'(1) && !complete_ff)
      else $error("start character did not restart the frame");

endmodule

// ----- rtl/scfr_queue.sv -----
// ----------------------------------------------------------------------------
// scfr_queue
// Two-entry queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module scfr_queue import scfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type      entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("queue count out of range");

   a_ptr_match : assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue pointers disagree with count");

   a_count_track : assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a push");

endmodule

// ----- rtl/scfr_back.sv -----
// ----------------------------------------------------------------------------
// scfr_back
// Owns the frame store: carries out writes and reads, holds the result.
// ----------------------------------------------------------------------------
module scfr_back import scfr_pkg::*; #(
   parameter int BUFFER_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cmd_type           pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_frame_ready,
   output logic [LEN_W-1:0]  rsp_frame_length,
   output logic              rsp_read_valid,
   output logic [BYTE_W-1:0] rsp_read_data
);

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);

   logic [BYTE_W-1:0] store_mem [BUFFER_DEPTH];
   logic              valid_ff;
   logic              ready_ff;
   logic [LEN_W-1:0]  length_ff;
   logic              rd_valid_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              take;

   assign pop_ready = !valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ready_ff    <= pop_data.frame_ready;
         length_ff   <= pop_data.frame_length;
         rd_valid_ff <= pop_data.read_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pop_data.write_en) begin
         store_mem[pop_data.write_addr[ADDR_W-1:0]] <= pop_data.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pop_data.read_valid) begin
         rd_data_ff <= store_mem[pop_data.read_addr[ADDR_W-1:0]];
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_frame_ready  = ready_ff;
   assign rsp_frame_length = length_ff;
   assign rsp_read_valid   = rd_valid_ff;
   assign rsp_read_data    = rd_valid_ff ? rd_data_ff : '0;

   a_read_needs_frame : assert property (@(posedge clock) disable iff (reset)
      valid_ff && rd_valid_ff |-> ready_ff && rd_data_ff == rsp_read_data)
      else $error("read result without a complete frame");

   a_hold_on_stall : assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |=> valid_ff && $stable(length_ff) && $stable(ready_ff))
      else $error("result changed while stalled");

   a_no_write_with_read : assert property (@(posedge clock) disable iff (reset)
      take |-> !(pop_data.write_en && pop_data.read_valid))
      else $error("item both writes and reads the store");

endmodule

// ----- tb/start_char_crlf_frame_receiver_test.sv -----
// ----------------------------------------------------------------------------
// start_char_crlf_frame_receiver_test
// Self-checking bench for the asterisk-started, CR LF terminated frame receiver.
// ----------------------------------------------------------------------------
// A short table of directed items (reset state, reads and releases with no
// frame, bytes ahead of any asterisk, restart, the line feed check at short
// lengths, bytes after completion, the unused kind) runs first. A random part
// follows: one frame that overruns the store and completes at full length,
// then mostly well-formed frames with random content, mixed with noise and
// broken frames. Every accepted item is run through a local model of the
// frame logic, and every result is compared field by field with the oldest
// expectation. Both channels idle at random in several phases.
// ----------------------------------------------------------------------------
module start_char_crlf_frame_receiver_test;
   timeunit 1ns;
   timeprecision 1ps;

   import scfr_pkg::*;

   localparam int BUFFER_DEPTH  = 128;
   localparam int RESET_CYCLES  = 7;
   localparam int DRAIN_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 650;
   localparam int DIRECTED_ROWS = 27;

   // Kind code that the block does not use; it must only report status.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // Idling phases of the random part.
   localparam int PHASE_NONE     = 0;
   localparam int PHASE_SENDER   = 1;
   localparam int PHASE_RECEIVER = 2;
   localparam int PHASE_BOTH     = 3;

   typedef struct packed {
      logic              frame_ready;
      logic [LEN_W-1:0]  frame_length;
      logic              read_valid;
      logic [BYTE_W-1:0] read_data;
   } frame_status_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BYTE_W-1:0]  rx_byte;
      logic [INDEX_W-1:0] read_index;
      logic               fixed;   // status below is the expectation
      frame_status_type   status;
   } stim_item_type;

   // Directed table. Rows with fixed set carry the status typed in; the
   // others are checked against the local model.
   localparam stim_item_type DIRECTED [DIRECTED_ROWS] = '{
      // nothing held after reset: read, release and unused kind do nothing
      '{KIND_READ,    8'h00, 7'd0,   1'b1, '{1'b0, 8'd0, 1'b0, 8'h00}},
      '{KIND_RELEASE, 8'h00, 7'd0,   1'b1, '{1'b0, 8'd0, 1'b0, 8'h00}},
      '{KIND_UNUSED,  8'hFF, 7'h7F,  1'b1, '{1'b0, 8'd0, 1'b0, 8'h00}},
      // bytes ahead of any asterisk append from position 0
      '{KIND_BYTE,    8'h00, 7'd0,   1'b1, '{1'b0, 8'd1, 1'b0, 8'h00}},
      '{KIND_BYTE,    8'hFF, 7'd0,   1'b1, '{1'b0, 8'd2, 1'b0, 8'h00}},
      // asterisk restarts, then CR LF completes a three-byte frame
      '{KIND_BYTE,    8'h2A, 7'd0,   1'b1, '{1'b0, 8'd1, 1'b0, 8'h00}},
      '{KIND_BYTE,    8'h0D, 7'd0,   1'b1, '{1'b0, 8'd2, 1'b0, 8'h00}},
      '{KIND_BYTE,    8'h0A, 7'd0,   1'b1, '{1'b1, 8'd3, 1'b0, 8'h00}},
      '{KIND_READ,    8'h00, 7'd0,   1'b1, '{1'b1, 8'd3, 1'b1, 8'h2A}},
      '{KIND_READ,    8'h00, 7'd2,   1'b1, '{1'b1, 8'd3, 1'b1, 8'h0A}},
      // read past the length
      '{KIND_READ,    8'h00, 7'd3,   1'b1, '{1'b1, 8'd3, 1'b0, 8'h00}},
      // bytes after completion are ignored
      '{KIND_BYTE,    8'h41, 7'd0,   1'b1, '{1'b1, 8'd3, 1'b0, 8'h00}},
      '{KIND_BYTE,    8'h0D, 7'd0,   1'b1, '{1'b1, 8'd3, 1'b0, 8'h00}},
      '{KIND_UNUSED,  8'h00, 7'd1,   1'b1, '{1'b1, 8'd3, 1'b0, 8'h00}},
      // release, then release and read with nothing held
      '{KIND_RELEASE, 8'h00, 7'd0,   1'b1, '{1'b0, 8'd0, 1'b0, 8'h00}},
      '{KIND_RELEASE, 8'h00, 7'd0,   1'b1, '{1'b0, 8'd0, 1'b0, 8'h00}},
      '{KIND_READ,    8'h00, 7'd0,   1'b1, '{1'b0, 8'd0, 1'b0, 8'h00}},
      // frame with no asterisk: LF CR LF
      '{KIND_BYTE,    8'h0A, 7'd0,   1'b0, '0},
      '{KIND_BYTE,    8'h0D, 7'd0,   1'b0, '0},
      '{KIND_BYTE,    8'h0A, 7'd0,   1'b0, '0},
      '{KIND_READ,    8'h00, 7'd1,   1'b0, '0},
      // asterisk on a completed frame restarts it
      '{KIND_BYTE,    8'h2A, 7'd0,   1'b1, '{1'b0, 8'd1, 1'b0, 8'h00}},
      // line feed at length two does not complete
      '{KIND_BYTE,    8'h0A, 7'd0,   1'b0, '0},
      '{KIND_BYTE,    8'h0D, 7'd0,   1'b0, '0},
      '{KIND_BYTE,    8'h0A, 7'd0,   1'b0, '0},
      '{KIND_READ,    8'h00, 7'd3,   1'b0, '0},
      '{KIND_RELEASE, 8'h00, 7'd0,   1'b0, '0}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [KIND_W-1:0]  req_kind;
   logic [BYTE_W-1:0]  req_rx_byte;
   logic [INDEX_W-1:0] req_read_index;
   logic               rsp_valid;
   logic               rsp_ready;
   logic               rsp_frame_ready;
   logic [LEN_W-1:0]   rsp_frame_length;
   logic               rsp_read_valid;
   logic [BYTE_W-1:0]  rsp_read_data;

   // Local copy of the frame state.
   logic [BYTE_W-1:0] frame_copy [BUFFER_DEPTH];
   logic [LEN_W-1:0]  held_count;
   logic              frame_held;

   stim_item_type    stim_q [$];
   frame_status_type status_q [$];
   stim_item_type    drive_item;
   frame_status_type predicted;
   frame_status_type oldest;
   int               idle_phase;
   int               fault_count;
   int               cycle_count;

   start_char_crlf_frame_receiver #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_rx_byte(req_rx_byte),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_ready(rsp_frame_ready),
      .rsp_frame_length(rsp_frame_length),
      .rsp_read_valid(rsp_read_valid),
      .rsp_read_data(rsp_read_data)
   );

   always #5 clock = ~clock;

   // Advance the local frame state by one item and return the status after it.
   function automatic frame_status_type predict_frame_status(logic [KIND_W-1:0] kind,
                                                             logic [BYTE_W-1:0] rx,
                                                             logic [INDEX_W-1:0] index);
      frame_status_type s;
      logic [LEN_W-1:0] pos;
      s = '0;
      case (kind)
         KIND_BYTE: begin
            if (rx == START_CHAR) begin
               // an asterisk always restarts, even on a completed frame
               frame_held    = 1'b0;
               frame_copy[0] = rx;
               held_count    = 8'd1;
            end else if (!frame_held) begin
               // drop the byte once the store is full
               if (held_count < LEN_W'(BUFFER_DEPTH)) begin
                  frame_copy[held_count[INDEX_W-1:0]] = rx;
                  held_count                          = held_count + 8'd1;
               end
               pos = held_count - 8'd2;
               if (rx == LINE_FEED && held_count > 8'd2 &&
                   frame_copy[pos[INDEX_W-1:0]] == CARRIAGE_RETURN)
                  frame_held = 1'b1;
            end
         end
         KIND_READ: begin
            if (frame_held && LEN_W'(index) < held_count) begin
               s.read_valid = 1'b1;
               s.read_data  = frame_copy[index];
            end
         end
         KIND_RELEASE: begin
            if (frame_held && held_count != 8'd0) begin
               frame_held = 1'b0;
               held_count = 8'd0;
            end
         end
         default: ;
      endcase
      s.frame_ready  = frame_held;
      s.frame_length = held_count;
      return s;
   endfunction

   function automatic int idle_pct(int phase, bit receiver_side);
      if (phase == PHASE_BOTH)
         return 9;
      if (phase == (receiver_side ? PHASE_RECEIVER : PHASE_SENDER))
         return 69;
      return 0;
   endfunction

   // Random byte and random store index at their field widths.
   function automatic logic [BYTE_W-1:0] random_byte();
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [INDEX_W-1:0] random_index(int unsigned hi);
      return INDEX_W'($urandom_range(0, hi));
   endfunction

   // Random byte that is none of the framing characters.
   function automatic logic [BYTE_W-1:0] plain_byte();
      logic [BYTE_W-1:0] b;
      do
         b = random_byte();
      while (b == START_CHAR || b == LINE_FEED || b == CARRIAGE_RETURN);
      return b;
   endfunction

   task automatic push_item(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] rx,
                            logic [INDEX_W-1:0] index);
      stim_item_type it;
      it            = '0;
      it.kind       = kind;
      it.rx_byte    = rx;
      it.read_index = index;
      stim_q.push_back(it);
   endtask

   // One noise item: framing characters, random bytes, stray reads, releases, unused kind.
   task automatic push_noise();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) begin
         case ($urandom_range(0, 2))
            0:       push_item(KIND_BYTE, START_CHAR, random_index(127));
            1:       push_item(KIND_BYTE, LINE_FEED, random_index(127));
            default: push_item(KIND_BYTE, CARRIAGE_RETURN, random_index(127));
         endcase
      end else if (roll < 50)
         push_item(KIND_BYTE, random_byte(), random_index(127));
      else if (roll < 70)
         push_item(KIND_READ, random_byte(), random_index(127));
      else if (roll < 85)
         push_item(KIND_RELEASE, random_byte(), random_index(127));
      else
         push_item(KIND_UNUSED, random_byte(), random_index(127));
   endtask

   // Check each result against the oldest expectation; record each accepted item.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (status_q.size() == 0) begin
               $display("%0t: result with nothing expected: ready %0b length %0d valid %0b data %02h",
                        $time, rsp_frame_ready, rsp_frame_length, rsp_read_valid,
                        rsp_read_data);
               fault_count++;
            end else begin
               oldest = status_q.pop_front();
               if (rsp_frame_ready !== oldest.frame_ready) begin
                  $display("%0t: frame_ready expected %0b actual %0b",
                           $time, oldest.frame_ready, rsp_frame_ready);
                  fault_count++;
               end
               if (rsp_frame_length !== oldest.frame_length) begin
                  $display("%0t: frame_length expected %0d actual %0d",
                           $time, oldest.frame_length, rsp_frame_length);
                  fault_count++;
               end
               if (rsp_read_valid !== oldest.read_valid) begin
                  $display("%0t: read_valid expected %0b actual %0b",
                           $time, oldest.read_valid, rsp_read_valid);
                  fault_count++;
               end
               if (rsp_read_data !== oldest.read_data) begin
                  $display("%0t: read_data expected %02h actual %02h",
                           $time, oldest.read_data, rsp_read_data);
                  fault_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            // keep the model in step on every item, typed-in rows too
            predicted = predict_frame_status(drive_item.kind, drive_item.rx_byte,
                                             drive_item.read_index);
            status_q.push_back(drive_item.fixed ? drive_item.status : predicted);
         end
      end
   end

   // Receiver side: stall at random according to the phase.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= idle_pct(idle_phase, 1'b1));

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int body_len;
      int frame_len;
      int n;
      int roll;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_kind       = KIND_BYTE;
      req_rx_byte    = '0;
      req_read_index = '0;
      rsp_ready      = 1'b0;
      idle_phase     = PHASE_NONE;
      fault_count    = 0;
      cycle_count    = 0;
      held_count     = '0;
      frame_held     = 1'b0;
      drive_item     = '0;

      foreach (DIRECTED[r])
         stim_q.push_back(DIRECTED[r]);

      // Overrun the store: CR at the last but one place, one byte at the last,
      // further bytes dropped, then a line feed completes at full length. After
      // this every entry has been written, so any index may be read.
      push_item(KIND_BYTE, START_CHAR, 7'd0);
      for (int k = 1; k < BUFFER_DEPTH - 2; k++)
         push_item(KIND_BYTE, plain_byte(), 7'd0);
      push_item(KIND_BYTE, CARRIAGE_RETURN, 7'd0);
      repeat (5)
         push_item(KIND_BYTE, plain_byte(), 7'd0);
      push_item(KIND_BYTE, LINE_FEED, 7'd0);
      repeat (6)
         push_item(KIND_READ, random_byte(), random_index(127));
      push_item(KIND_READ, 8'h00, 7'h7F);
      push_item(KIND_RELEASE, 8'h00, 7'd0);

      // Mostly well-formed frames with random content, the rest noise and
      // broken frames.
      while (stim_q.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 70) begin
            body_len = ($urandom_range(0, 99) < 3) ? $urandom_range(100, 130)
                                                   : $urandom_range(0, 12);
            push_item(KIND_BYTE, START_CHAR, random_index(127));
            for (int k = 0; k < body_len; k++) begin
               roll = $urandom_range(0, 99);
               if (roll < 4)
                  push_noise();
               else if (roll < 8)
                  push_item(KIND_BYTE, random_byte(), random_index(127));
               else
                  push_item(KIND_BYTE, plain_byte(), random_index(127));
            end
            if ($urandom_range(0, 99) < 90)
               push_item(KIND_BYTE, CARRIAGE_RETURN, random_index(127));
            if ($urandom_range(0, 99) < 90)
               push_item(KIND_BYTE, LINE_FEED, random_index(127));
            frame_len = (body_len + 3 > BUFFER_DEPTH - 1) ? BUFFER_DEPTH - 1 : body_len + 3;
            repeat ($urandom_range(1, 6)) begin
               if ($urandom_range(0, 99) < 80)
                  push_item(KIND_READ, random_byte(), random_index(frame_len));
               else
                  push_item(KIND_READ, random_byte(), random_index(127));
            end
            if ($urandom_range(0, 99) < 20)
               push_item(KIND_BYTE, random_byte(), random_index(127));
            if ($urandom_range(0, 99) < 90)
               push_item(KIND_RELEASE, random_byte(), random_index(127));
         end else begin
            repeat ($urandom_range(1, 8))
               push_noise();
         end
      end

      // Hold reset, then release it on a falling edge.
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Drive each item at a falling edge and hold it until accepted.
      foreach (stim_q[i]) begin
         n = i - DIRECTED_ROWS;
         idle_phase = (n < 0) ? PHASE_NONE : (n * 4) / (stim_q.size() - DIRECTED_ROWS);
         while ($urandom_range(0, 99) < idle_pct(idle_phase, 1'b0)) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         drive_item      = stim_q[i];
         req_valid      <= 1'b1;
         req_kind       <= stim_q[i].kind;
         req_rx_byte    <= stim_q[i].rx_byte;
         req_read_index <= stim_q[i].read_index;
         do
            @(posedge clock);
         while (!req_ready);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      // Wait for the outstanding results, then watch for strays.
      while (status_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/scfr_pkg.sv
rtl/scfr_front.sv
rtl/scfr_queue.sv
rtl/scfr_back.sv
rtl/start_char_crlf_frame_receiver.sv
tb/start_char_crlf_frame_receiver_test.sv
